### src/s3f_pkg.sv
// S3-FIFO eviction engine: shared word types, register map and constants.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package s3f_pkg;

  localparam int ADDR_W      = 4;
  localparam int MAX_RESULTS = 64;

  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_ACCESS = 2'd1;
  localparam logic [1:0] KIND_ERASE  = 2'd2;
  localparam logic [1:0] KIND_EVICT  = 2'd3;

  localparam logic [1:0] REG_RATIO    = 2'd0;
  localparam logic [1:0] REG_MAX_FREQ = 2'd1;
  localparam logic [1:0] REG_FLOOR    = 2'd2;

  localparam logic [8:0] RATIO_RESET    = 9'd26;
  localparam logic [8:0] RATIO_FULL     = 9'd256;
  localparam logic [2:0] MAX_FREQ_RESET = 3'd3;
  localparam logic [6:0] FLOOR_RESET    = 7'd16;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  slot;
    logic [63:0] entry_key;
    logic [31:0] entry_size;
    logic [37:0] need_bytes;
    logic [6:0]  need_files;
  } in_word_t;

  typedef struct packed {
    logic        ghost_hit;
    logic        victim_valid;
    logic [5:0]  victim_slot;
    logic [31:0] victim_size;
    logic        last;
  } out_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        in_range;
    logic [5:0]  slot;
    logic [63:0] key;
    logic [31:0] size;
    logic [37:0] need_bytes;
    logic [6:0]  need_files;
  } cmd_t;

  typedef struct packed {
    logic [8:0] ratio;
    logic [2:0] max_freq;
    logic [6:0] floor;
  } cfg_t;

endpackage

### src/s3f_front.sv
// S3-FIFO front end: accepts request words, classifies them and queues them.
// Depends on s3f_pkg.
`timescale 1ns / 1ps

module s3f_front #(
  parameter int ENTRIES = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  s3f_pkg::in_word_t req,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output s3f_pkg::cmd_t     cmd
);
  import s3f_pkg::*;

  in_word_t   fifo [2];
  logic       wp;
  logic       rp;
  logic [1:0] fill;
  logic       push;
  logic       pop;
  in_word_t   head_word;

  assign req_ready = (fill != 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign push      = req_valid && req_ready;
  assign pop       = cmd_valid && cmd_ready;
  assign head_word = fifo[rp];

  always_comb begin
    cmd.kind       = head_word.kind;
    cmd.in_range   = (32'(head_word.slot) < 32'(ENTRIES));
    cmd.slot       = head_word.slot;
    cmd.key        = head_word.entry_key;
    cmd.size       = head_word.entry_size;
    cmd.need_bytes = head_word.need_bytes;
    cmd.need_files = head_word.need_files;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wp] <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

### src/s3f_back.sv
// S3-FIFO back end: slot lists, ghost ring and eviction sequencer.
// Depends on s3f_pkg; fed by s3f_front, drives the response register.
`timescale 1ns / 1ps

module s3f_back #(
  parameter int ENTRIES     = 64,
  parameter int GHOST_DEPTH = 64,
  parameter int SIZE_BITS   = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  s3f_pkg::cmd_t      cmd,
  input  s3f_pkg::cfg_t      cfg,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output s3f_pkg::out_word_t rsp
);
  import s3f_pkg::*;

  localparam int IW  = $clog2(ENTRIES);
  localparam int GW  = $clog2(GHOST_DEPTH);
  localparam int CW  = $clog2(ENTRIES + 1);
  localparam int SW  = $clog2(GHOST_DEPTH + 1);
  localparam int BW  = SIZE_BITS + CW;
  localparam int TW  = BW + 1;
  localparam int FW  = (SIZE_BITS + 7 > 38) ? SIZE_BITS + 7 : 38;
  localparam int KW0 = (CW + 1 > 7) ? CW + 1 : 7;
  localparam int KW  = (KW0 > SW) ? KW0 : SW;

  typedef struct packed {
    logic [IW-1:0]        nxt;
    logic [IW-1:0]        prv;
    logic [63:0]          key;
    logic [SIZE_BITS-1:0] size;
    logic [2:0]           freq;
    logic                 in_main;
  } rec_t;

  typedef enum logic [19:0] {
    ST_IDLE     = 20'h00001,
    ST_ACC      = 20'h00002,
    ST_GSCAN    = 20'h00004,
    ST_GADD     = 20'h00008,
    ST_GTRIM    = 20'h00010,
    ST_PUSH     = 20'h00020,
    ST_PUSH_WR  = 20'h00040,
    ST_PUSH_END = 20'h00080,
    ST_ULOAD    = 20'h00100,
    ST_UPREV    = 20'h00200,
    ST_UPREV_WR = 20'h00400,
    ST_UNEXT    = 20'h00800,
    ST_UNEXT_WR = 20'h01000,
    ST_UDONE    = 20'h02000,
    ST_EVICTED  = 20'h04000,
    ST_ELOOP    = 20'h08000,
    ST_ECALC    = 20'h10000,
    ST_EDEC     = 20'h20000,
    ST_EFIN     = 20'h40000,
    ST_RESP     = 20'h80000
  } state_t;

  rec_t        slot_mem [ENTRIES];
  logic [63:0] ghost_mem [GHOST_DEPTH];

  rec_t          mrd;
  logic          m_we;
  logic [IW-1:0] m_wa;
  rec_t          m_wd;
  logic [IW-1:0] m_ra;
  logic [63:0]   grd;
  logic          g_we;
  logic [GW-1:0] g_ra;

  state_t               state;
  cmd_t                 op;
  logic [IW-1:0]        s;
  rec_t                 cur;
  logic                 q;
  logic [ENTRIES-1:0]   live;
  logic [GHOST_DEPTH-1:0] gvalid;
  logic [IW-1:0]        head [2];
  logic [IW-1:0]        tail [2];
  logic [CW-1:0]        cnt [2];
  logic [BW-1:0]        bytes [2];
  logic [GW-1:0]        ghead;
  logic [SW-1:0]        gspan;
  logic [SW-1:0]        gvcnt;
  logic [GW-1:0]        gcnt;
  logic [GW-1:0]        gidx;
  logic                 gpend;
  logic                 ghit;
  logic [FW-1:0]        fb;
  logic [6:0]           ff;
  logic [6:0]           nres;
  logic                 pend_v;
  logic [IW-1:0]        pend_slot;
  logic [SIZE_BITS-1:0] pend_size;
  logic [TW-1:0]        target;

  logic                 uq;
  logic                 rsp_free;
  logic                 rsp_load;
  logic [IW-1:0]        cmd_idx;
  logic                 g_found;
  logic                 g_last;
  logic [GW:0]          pos_sum;
  logic [GW-1:0]        g_pos;
  logic [GW-1:0]        ghead_inc;
  logic [KW-1:0]        live_sum;
  logic [KW-1:0]        cap;
  logic                 trim;
  logic [8:0]           r9;
  logic [TW-1:0]        total;
  logic [TW+8:0]        t_hi;
  logic [16:0]          t_lo;
  logic [TW-1:0]        target_next;
  logic                 use_small;
  logic                 loop_go;

  assign uq        = cur.in_main;
  assign rsp_free  = !rsp_valid || rsp_ready;
  assign rsp_load  = rsp_free && (((state == ST_EVICTED) && pend_v) ||
                                  (state == ST_EFIN) || (state == ST_RESP));
  assign cmd_ready = (state == ST_IDLE);
  assign cmd_idx   = IW'(cmd.slot);
  assign g_found   = gpend && gvalid[gidx] && (grd == cur.key);
  assign g_last    = gpend && (gidx == GW'(GHOST_DEPTH - 1));
  assign pos_sum   = (GW + 1)'(ghead) + (GW + 1)'(gspan);
  assign g_pos     = (pos_sum >= (GW + 1)'(GHOST_DEPTH)) ?
                     GW'(pos_sum - (GW + 1)'(GHOST_DEPTH)) : GW'(pos_sum);
  assign ghead_inc = (ghead == GW'(GHOST_DEPTH - 1)) ? '0 : ghead + 1'b1;
  assign live_sum  = KW'(cnt[0]) + KW'(cnt[1]);
  assign cap       = (live_sum < KW'(cfg.floor)) ? KW'(cfg.floor) : live_sum;
  assign trim      = (KW'(gvcnt) > cap) && (gspan != '0);

  always_comb begin
    r9          = (cfg.ratio > RATIO_FULL) ? RATIO_FULL : cfg.ratio;
    total       = TW'(bytes[0]) + TW'(bytes[1]);
    t_hi        = (TW + 9)'(total >> 8) * (TW + 9)'(r9);
    t_lo        = 17'(total[7:0]) * 17'(r9);
    target_next = TW'(t_hi) + TW'(t_lo[16:8]);
    use_small   = ((cnt[0] != '0) && (TW'(bytes[0]) >= target)) || (cnt[1] == '0);
    loop_go     = ((fb < FW'(op.need_bytes)) || (ff < op.need_files)) &&
                  ((cnt[0] != '0) || (cnt[1] != '0)) &&
                  (nres < 7'(MAX_RESULTS));
  end

  always_comb begin
    m_we = 1'b0;
    m_wa = s;
    m_wd = cur;
    m_ra = s;
    g_we = 1'b0;
    g_ra = gcnt;
    unique case (state)
      ST_IDLE: begin
        m_ra = cmd_idx;
      end
      ST_ACC: begin
        m_we = 1'b1;
        m_wd = mrd;
        if (mrd.freq < cfg.max_freq) begin
          m_wd.freq = mrd.freq + 3'd1;
        end
      end
      ST_UPREV: begin
        m_ra = cur.prv;
      end
      ST_UPREV_WR: begin
        m_we     = 1'b1;
        m_wa     = cur.prv;
        m_wd     = mrd;
        m_wd.nxt = cur.nxt;
      end
      ST_UNEXT: begin
        m_ra = cur.nxt;
      end
      ST_UNEXT_WR: begin
        m_we     = 1'b1;
        m_wa     = cur.nxt;
        m_wd     = mrd;
        m_wd.prv = cur.prv;
      end
      ST_PUSH: begin
        m_ra = tail[q];
      end
      ST_PUSH_WR: begin
        m_we     = 1'b1;
        m_wa     = cur.prv;
        m_wd     = mrd;
        m_wd.nxt = s;
      end
      ST_PUSH_END: begin
        m_we = 1'b1;
      end
      ST_EDEC: begin
        m_ra = use_small ? head[0] : head[1];
      end
      ST_GADD: begin
        g_we = (gspan != SW'(GHOST_DEPTH));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (m_we) begin
      slot_mem[m_wa] <= m_wd;
    end
    mrd <= slot_mem[m_ra];
  end

  always_ff @(posedge clk) begin
    if (g_we) begin
      ghost_mem[g_pos] <= cur.key;
    end
    grd <= ghost_mem[g_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      live      <= '0;
      gvalid    <= '0;
      head[0]   <= '0;
      head[1]   <= '0;
      tail[0]   <= '0;
      tail[1]   <= '0;
      cnt[0]    <= '0;
      cnt[1]    <= '0;
      bytes[0]  <= '0;
      bytes[1]  <= '0;
      ghead     <= '0;
      gspan     <= '0;
      gvcnt     <= '0;
      gpend     <= 1'b0;
      pend_v    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (cmd_valid) begin
            op     <= cmd;
            s      <= cmd_idx;
            ghit   <= 1'b0;
            fb     <= '0;
            ff     <= '0;
            nres   <= '0;
            pend_v <= 1'b0;
            if (cmd.kind == KIND_EVICT) begin
              state <= ST_ELOOP;
            end else if (!cmd.in_range) begin
              state <= ST_RESP;
            end else begin
              unique case (cmd.kind)
                KIND_INSERT: begin
                  if (live[cmd_idx]) begin
                    state <= ST_RESP;
                  end else begin
                    live[cmd_idx] <= 1'b1;
                    cur.key       <= cmd.key;
                    cur.size      <= SIZE_BITS'(cmd.size);
                    cur.freq      <= 3'd0;
                    gpend         <= 1'b0;
                    gcnt          <= '0;
                    state         <= ST_GSCAN;
                  end
                end
                KIND_ACCESS: begin
                  state <= live[cmd_idx] ? ST_ACC : ST_RESP;
                end
                default: begin
                  if (live[cmd_idx]) begin
                    live[cmd_idx] <= 1'b0;
                    state         <= ST_ULOAD;
                  end else begin
                    state <= ST_RESP;
                  end
                end
              endcase
            end
          end
        end
        ST_ACC: begin
          state <= ST_RESP;
        end
        ST_GSCAN: begin
          if (g_found || g_last) begin
            gpend <= 1'b0;
            if (op.kind == KIND_INSERT) begin
              if (g_found) begin
                gvalid[gidx] <= 1'b0;
                gvcnt        <= gvcnt - 1'b1;
                ghit         <= 1'b1;
              end
              q     <= g_found;
              state <= ST_PUSH;
            end else begin
              state <= g_found ? ST_EVICTED : ST_GADD;
            end
          end else begin
            gpend <= 1'b1;
            gidx  <= gcnt;
            gcnt  <= gcnt + 1'b1;
          end
        end
        ST_GADD: begin
          if (gspan == SW'(GHOST_DEPTH)) begin
            if (gvalid[ghead]) begin
              gvalid[ghead] <= 1'b0;
              gvcnt         <= gvcnt - 1'b1;
            end
            ghead <= ghead_inc;
            gspan <= gspan - 1'b1;
          end else begin
            gvalid[g_pos] <= 1'b1;
            gspan         <= gspan + 1'b1;
            gvcnt         <= gvcnt + 1'b1;
            state         <= ST_GTRIM;
          end
        end
        ST_GTRIM: begin
          if (trim) begin
            if (gvalid[ghead]) begin
              gvalid[ghead] <= 1'b0;
              gvcnt         <= gvcnt - 1'b1;
            end
            ghead <= ghead_inc;
            gspan <= gspan - 1'b1;
          end else begin
            state <= ST_EVICTED;
          end
        end
        ST_PUSH: begin
          cur.in_main <= q;
          if (cnt[q] == '0) begin
            head[q] <= s;
            state   <= ST_PUSH_END;
          end else begin
            cur.prv <= tail[q];
            state   <= ST_PUSH_WR;
          end
          tail[q]  <= s;
          cnt[q]   <= cnt[q] + 1'b1;
          bytes[q] <= bytes[q] + BW'(cur.size);
        end
        ST_PUSH_WR: begin
          state <= ST_PUSH_END;
        end
        ST_PUSH_END: begin
          state <= (op.kind == KIND_INSERT) ? ST_RESP : ST_ELOOP;
        end
        ST_ULOAD: begin
          cur   <= mrd;
          state <= ST_UPREV;
        end
        ST_UPREV: begin
          if (head[uq] == s) begin
            head[uq] <= cur.nxt;
            state    <= ST_UNEXT;
          end else begin
            state <= ST_UPREV_WR;
          end
        end
        ST_UPREV_WR: begin
          state <= ST_UNEXT;
        end
        ST_UNEXT: begin
          cnt[uq]   <= cnt[uq] - 1'b1;
          bytes[uq] <= bytes[uq] - BW'(cur.size);
          if (tail[uq] == s) begin
            tail[uq] <= cur.prv;
            state    <= ST_UDONE;
          end else begin
            state <= ST_UNEXT_WR;
          end
        end
        ST_UNEXT_WR: begin
          state <= ST_UDONE;
        end
        ST_UDONE: begin
          if (op.kind == KIND_ERASE) begin
            state <= ST_RESP;
          end else if (cur.freq != 3'd0) begin
            if (cur.in_main) begin
              cur.freq <= cur.freq - 3'd1;
            end
            q     <= 1'b1;
            state <= ST_PUSH;
          end else begin
            live[s] <= 1'b0;
            if (cur.in_main) begin
              state <= ST_EVICTED;
            end else begin
              gpend <= 1'b0;
              gcnt  <= '0;
              state <= ST_GSCAN;
            end
          end
        end
        ST_EVICTED: begin
          if (!pend_v || rsp_free) begin
            if (pend_v) begin
              rsp <= '{1'b0, 1'b1, 6'(pend_slot), 32'(pend_size), 1'b0};
            end
            pend_v    <= 1'b1;
            pend_slot <= s;
            pend_size <= cur.size;
            fb        <= fb + FW'(cur.size);
            ff        <= ff + 7'd1;
            nres      <= nres + 7'd1;
            state     <= ST_ELOOP;
          end
        end
        ST_ELOOP: begin
          state <= loop_go ? ST_ECALC : ST_EFIN;
        end
        ST_ECALC: begin
          target <= target_next;
          state  <= ST_EDEC;
        end
        ST_EDEC: begin
          s     <= use_small ? head[0] : head[1];
          state <= ST_ULOAD;
        end
        ST_EFIN: begin
          if (rsp_free) begin
            if (pend_v) begin
              rsp <= '{1'b0, 1'b1, 6'(pend_slot), 32'(pend_size), 1'b1};
            end else begin
              rsp <= '{1'b0, 1'b0, 6'd0, 32'd0, 1'b1};
            end
            state <= ST_IDLE;
          end
        end
        ST_RESP: begin
          if (rsp_free) begin
            rsp   <= '{ghit, 1'b0, 6'd0, 32'd0, 1'b1};
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

### src/s3fifo_eviction_policy.sv
// S3-FIFO eviction engine top level: register port, front end and back end.
// Depends on s3f_pkg, s3f_front and s3f_back.
//
//   channel | direction | handshake            | word
//   req     | in        | req_valid/req_ready  | in_word_t: kind, slot, key, size, wants
//   rsp     | out       | rsp_valid/rsp_ready  | out_word_t: ghost hit, victim, last
//   apb     | in/out    | psel/penable/pready  | ratio, max_freq, ghost_floor
//
// Insert sweeps the ghost ring at most once, stopping at a hit, through the
// single read port of the ghost key memory. A victim taken from small adds
// a ghost sweep to its eviction step and, if its key is new, a ghost add and
// trim. Reset is synchronous and needs no clearing pass. The front queue
// holds two words while the back end is busy or the response register is full.
`timescale 1ns / 1ps

module s3fifo_eviction_policy #(
  parameter int ENTRIES     = 64,
  parameter int GHOST_DEPTH = 64,
  parameter int SIZE_BITS   = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [s3f_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  s3f_pkg::in_word_t            req,
  output logic                         rsp_valid,
  input  logic                         rsp_ready,
  output s3f_pkg::out_word_t           rsp
);
  import s3f_pkg::*;

  cfg_t cfg;
  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ratio    <= RATIO_RESET;
      cfg.max_freq <= MAX_FREQ_RESET;
      cfg.floor    <= FLOOR_RESET;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_RATIO:    cfg.ratio    <= pwdata[8:0];
        REG_MAX_FREQ: cfg.max_freq <= pwdata[2:0];
        REG_FLOOR:    cfg.floor    <= pwdata[6:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_RATIO:    prdata = 32'(cfg.ratio);
      REG_MAX_FREQ: prdata = 32'(cfg.max_freq);
      REG_FLOOR:    prdata = 32'(cfg.floor);
      default:      prdata = 32'd0;
    endcase
  end

  s3f_front #(
    .ENTRIES (ENTRIES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  s3f_back #(
    .ENTRIES     (ENTRIES),
    .GHOST_DEPTH (GHOST_DEPTH),
    .SIZE_BITS   (SIZE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .cfg       (cfg),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

### verif/tb_top.sv
// Self-checking bench for s3fifo_eviction_policy: drives request words and APB
// register writes, predicts every response word with its own S3-FIFO model.
// Depends on s3f_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb_top;
  import s3f_pkg::*;

  localparam int NSLOT = 64;
  localparam int GDEPTH = 64;
  localparam int LIMIT = 20000000;

  logic clk;
  logic rst;
  logic psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic req_valid, req_ready, rsp_valid, rsp_ready;
  in_word_t req;
  out_word_t rsp;

  s3fifo_eviction_policy i_dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .req_valid(req_valid), .req_ready(req_ready), .req(req),
    .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // directed rows: kind, slot, key, size, byte and entry wants, expected word
  typedef struct {
    in_word_t w;
    bit typed;
    out_word_t e;
  } dir_row_t;

  dir_row_t rows[$];

  // predictor state
  logic [8:0] cur_ratio;
  logic [2:0] cur_max_freq;
  logic [6:0] cur_floor;
  logic [5:0] nxt[NSLOT], prv[NSLOT];
  logic [63:0] skey[NSLOT];
  logic [31:0] ssize[NSLOT];
  logic [2:0] sfreq[NSLOT];
  logic in_main[NSLOT], live[NSLOT];
  logic [5:0] qhead[2], qtail[2];
  int unsigned qcnt[2];
  logic [37:0] qbytes[2];
  logic [63:0] gkey[GDEPTH];
  logic gvalid[GDEPTH];
  int unsigned ghead, gspan, gcount;

  out_word_t expected_words[$];
  int errors;
  int unsigned cycle_count;
  bit in_idle_free;
  int unsigned accepted;

  function automatic void add_row(in_word_t w, bit typed, out_word_t e);
    dir_row_t row;
    row.w = w;
    row.typed = typed;
    row.e = e;
    rows.insert(rows.size(), row);
  endfunction

  function automatic void expect_word(out_word_t o);
    expected_words.insert(expected_words.size(), o);
  endfunction

  function automatic void model_reset();
    for (int i = 0; i < NSLOT; i++) begin
      live[i] = 1'b0;
      in_main[i] = 1'b0;
      sfreq[i] = '0;
    end
    for (int i = 0; i < GDEPTH; i++) gvalid[i] = 1'b0;
    for (int q = 0; q < 2; q++) begin
      qhead[q] = '0;
      qtail[q] = '0;
      qcnt[q] = 0;
      qbytes[q] = '0;
    end
    ghead = 0;
    gspan = 0;
    gcount = 0;
    cur_ratio = RATIO_RESET;
    cur_max_freq = MAX_FREQ_RESET;
    cur_floor = FLOOR_RESET;
  endfunction

  function automatic void unlink(int s);
    int q;
    q = in_main[s];
    if (qhead[q] == s) qhead[q] = nxt[s];
    else nxt[prv[s]] = nxt[s];
    if (qtail[q] == s) qtail[q] = prv[s];
    else prv[nxt[s]] = prv[s];
    qcnt[q]--;
    qbytes[q] -= ssize[s];
  endfunction

  function automatic void append(int q, int s);
    in_main[s] = q[0];
    if (qcnt[q] == 0) qhead[q] = s[5:0];
    else begin
      nxt[qtail[q]] = s[5:0];
      prv[s] = qtail[q];
    end
    qtail[q] = s[5:0];
    qcnt[q]++;
    qbytes[q] += ssize[s];
  endfunction

  function automatic int ghost_lookup(logic [63:0] k);
    for (int i = 0; i < GDEPTH; i++)
      if (gvalid[i] && gkey[i] == k) return i;
    return -1;
  endfunction

  function automatic void ghost_drop_oldest();
    if (gspan == 0) return;
    if (gvalid[ghead]) begin
      gvalid[ghead] = 1'b0;
      gcount--;
    end
    ghead = (ghead + 1) % GDEPTH;
    gspan--;
  endfunction

  function automatic void ghost_push(logic [63:0] k);
    int unsigned cap, pos;
    if (ghost_lookup(k) >= 0) return;
    if (gspan >= GDEPTH) ghost_drop_oldest();
    pos = (ghead + gspan) % GDEPTH;
    gkey[pos] = k;
    gvalid[pos] = 1'b1;
    gspan++;
    gcount++;
    cap = qcnt[0] + qcnt[1];
    if (cap < cur_floor) cap = cur_floor;
    while (gcount > cap && gspan > 0) ghost_drop_oldest();
  endfunction

  function automatic int policy_step();
    logic [38:0] total;
    logic [47:0] target;
    int unsigned r;
    bit from_small;
    int s;
    total = qbytes[0] + qbytes[1];
    r = (cur_ratio > RATIO_FULL) ? 256 : cur_ratio;
    target = (48'(total >> 8) * r) + ((48'(total[7:0]) * r) >> 8);
    if (qcnt[0] > 0 && 48'(qbytes[0]) >= target) from_small = 1'b1;
    else if (qcnt[1] > 0) from_small = 1'b0;
    else if (qcnt[0] > 0) from_small = 1'b1;
    else return -1;
    s = from_small ? qhead[0] : qhead[1];
    unlink(s);
    if (sfreq[s] >= 1) begin
      if (!from_small) sfreq[s] = sfreq[s] - 3'd1;
      append(1, s);
      return -1;
    end
    live[s] = 1'b0;
    if (from_small) ghost_push(skey[s]);
    return s;
  endfunction

  function automatic void predict_words(in_word_t w);
    out_word_t o;
    int n, v;
    logic [38:0] got_bytes;
    int unsigned got_files;
    o = '0;
    if (w.kind == KIND_EVICT) begin
      n = 0;
      got_bytes = '0;
      got_files = 0;
      while ((got_bytes < 39'(w.need_bytes) || got_files < w.need_files) &&
             (qcnt[0] > 0 || qcnt[1] > 0) && n < MAX_RESULTS) begin
        v = policy_step();
        if (v >= 0) begin
          if (n > 0) expect_word(o);
          got_bytes += ssize[v];
          got_files++;
          o = '0;
          o.victim_valid = 1'b1;
          o.victim_slot = v[5:0];
          o.victim_size = ssize[v];
          n++;
        end
      end
      o.last = 1'b1;
      expect_word(o);
      return;
    end
    o.last = 1'b1;
    case (w.kind)
      KIND_INSERT: begin
        if (!live[w.slot]) begin
          live[w.slot] = 1'b1;
          skey[w.slot] = w.entry_key;
          ssize[w.slot] = w.entry_size;
          sfreq[w.slot] = '0;
          v = ghost_lookup(w.entry_key);
          if (v >= 0) begin
            gvalid[v] = 1'b0;
            gcount--;
            append(1, w.slot);
            o.ghost_hit = 1'b1;
          end else append(0, w.slot);
        end
      end
      KIND_ACCESS: begin
        if (live[w.slot] && sfreq[w.slot] < cur_max_freq) sfreq[w.slot]++;
      end
      default: begin
        if (live[w.slot]) begin
          unlink(w.slot);
          live[w.slot] = 1'b0;
        end
      end
    endcase
    expect_word(o);
  endfunction

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_RATIO: cur_ratio = val[8:0];
      REG_MAX_FREQ: cur_max_freq = val[2:0];
      default: cur_floor = val[6:0];
    endcase
  endtask

  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
    repeat (2000) @(posedge clk);
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0) @(posedge clk);
  endtask

  task automatic send(in_word_t w, bit typed, out_word_t e);
    if (!in_idle_free) begin
      while ($urandom_range(99) < 34) begin
        req_valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_valid <= 1'b1;
    req <= w;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predict_words(w);
    if (typed) expected_words[expected_words.size() - 1] = e;
    accepted++;
  endtask

  function automatic in_word_t make_word(logic [1:0] k, logic [5:0] s, logic [63:0] key,
                                         logic [31:0] sz, logic [37:0] wb, logic [6:0] wf);
    in_word_t w;
    w.kind = k;
    w.slot = s;
    w.entry_key = key;
    w.entry_size = sz;
    w.need_bytes = wb;
    w.need_files = wf;
    return w;
  endfunction

  function automatic in_word_t random_word(int unsigned key_span);
    in_word_t w;
    logic [159:0] rnd;
    int unsigned p;
    rnd = {$urandom, $urandom, $urandom, $urandom, $urandom};
    w = rnd[$bits(in_word_t)-1:0];
    p = $urandom_range(99);
    if (p < 40) w.kind = KIND_INSERT;
    else if (p < 65) w.kind = KIND_ACCESS;
    else if (p < 80) w.kind = KIND_ERASE;
    else w.kind = KIND_EVICT;
    if ($urandom_range(9) != 0) begin
      w.entry_key = 64'($urandom_range(key_span));
      w.entry_size = $urandom_range(1, 5000);
      w.need_bytes = 38'($urandom_range(20000));
      w.need_files = 7'($urandom_range(6));
    end else if ($urandom_range(3) == 0) w.need_files = 7'($urandom_range(64));
    return w;
  endfunction

  // response checker
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word %p", $realtime, rsp);
        errors++;
      end else begin
        if (rsp !== expected_words[0]) begin
          $display("%0t: mismatch expected %p actual %p", $realtime, expected_words[0], rsp);
          errors++;
        end
        expected_words.delete(0);
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    if (rst) rsp_ready <= 1'b0;
    else rsp_ready <= in_idle_free ? 1'b1 : ($urandom_range(99) >= 34);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    dir_row_t r;
    out_word_t last_only;
    in_word_t w;
    cycle_count = 0;
    errors = 0;
    accepted = 0;
    in_idle_free = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    req_valid = 1'b0;
    req = '0;
    model_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    last_only = '0;
    last_only.last = 1'b1;
    // evict on empty, access/erase free slot, insert extremes, repeat insert
    add_row(make_word(KIND_EVICT, 0, 0, 0, '1, 7'd64), 1'b1, last_only);
    add_row(make_word(KIND_ACCESS, 6'd63, 0, 0, 0, 0), 1'b1, last_only);
    add_row(make_word(KIND_ERASE, 6'd5, 0, 0, 0, 0), 1'b1, last_only);
    add_row(make_word(KIND_INSERT, 0, '1, '1, 0, 0), 1'b1, last_only);
    add_row(make_word(KIND_INSERT, 6'd63, 0, 0, 0, 0), 1'b1, last_only);
    add_row(make_word(KIND_INSERT, 0, 64'd7, 32'd9, 0, 0), 1'b1, last_only);
    add_row(make_word(KIND_INSERT, 6'd1, 64'd100, 32'd10, 0, 0), 1'b1, last_only);
    add_row(make_word(KIND_INSERT, 6'd2, 64'd200, 32'd20, 0, 0), 1'b1, last_only);
    for (int i = 0; i < 5; i++)
      add_row(make_word(KIND_ACCESS, 6'd1, 0, 0, 0, 0), 1'b1, last_only);
    add_row(make_word(KIND_ERASE, 6'd63, 0, 0, 0, 0), 1'b1, last_only);
    add_row(make_word(KIND_EVICT, 0, 0, 0, 0, 7'd2), 1'b0, last_only);
    add_row(make_word(KIND_EVICT, 0, 0, 0, 38'd1, 0), 1'b0, last_only);
    // ghost hit: the key of a slot evicted from small returns to main
    add_row(make_word(KIND_INSERT, 6'd9, '1, 32'd3, 0, 0), 1'b0, last_only);
    add_row(make_word(KIND_INSERT, 6'd10, 64'd200, 32'd4, 0, 0), 1'b0, last_only);
    add_row(make_word(KIND_EVICT, 0, 0, 0, '1, 7'd127), 1'b0, last_only);
    add_row(make_word(KIND_INSERT, 6'd11, 64'd200, 32'd5, 0, 0), 1'b0, last_only);
    add_row(make_word(KIND_EVICT, 6'd3, 0, 0, '1, 7'd127), 1'b0, last_only);

    foreach (rows[i]) begin
      r = rows[i];
      send(r.w, r.typed, r.e);
    end
    drain();

    // random phases over several register settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin reg_write(REG_RATIO, 0); reg_write(REG_MAX_FREQ, 1); reg_write(REG_FLOOR, 1); end
        1: begin reg_write(REG_RATIO, 256); reg_write(REG_MAX_FREQ, 7); reg_write(REG_FLOOR, 64); end
        2: begin reg_write(REG_RATIO, 511); reg_write(REG_MAX_FREQ, 0); reg_write(REG_FLOOR, 127); end
        3: begin reg_write(REG_RATIO, 26); reg_write(REG_MAX_FREQ, 3); reg_write(REG_FLOOR, 16); end
        default: begin
          reg_write(REG_RATIO, $urandom_range(256));
          reg_write(REG_MAX_FREQ, $urandom_range(1, 7));
          reg_write(REG_FLOOR, $urandom_range(1, 64));
        end
      endcase
      in_idle_free = (ph == 3);
      for (int n = 0; n < 80; n++) begin
        w = random_word(ph == 1 ? 400 : 90);
        send(w, 1'b0, last_only);
        if (ph == 2 && n == 40) settle();
      end
      drain();
    end

    if (errors == 0) $display("tb_top passed");
    else $display("tb_top failed");
    $finish;
  end

endmodule

### sim.f
src/s3f_pkg.sv
src/s3f_front.sv
src/s3f_back.sv
src/s3fifo_eviction_policy.sv
verif/tb_top.sv
